// ===== rtl/core/ctls_pkg.sv =====
// ----------------------------------------------------------------------------
// ctls_pkg
// Types, token kinds and character-class helpers for the token scanner.
// ----------------------------------------------------------------------------
package ctls_pkg;

   localparam int MAX_COMMENT_DEPTH = 255;
   localparam int DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);
   localparam int LEN_W = 16;
   localparam int OFS_W = 16;
   localparam int KIND_W = 6;
   localparam int RES_PER_ITEM = 3;
   localparam int RES_IDX_W = 2;
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);
   localparam int RSP_DATA_W = 40;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type K_EOF         = 6'd0;
   localparam kind_type K_IDENT       = 6'd1;
   localparam kind_type K_INT         = 6'd2;
   localparam kind_type K_FLOAT       = 6'd3;
   localparam kind_type K_TILDE       = 6'd4;
   localparam kind_type K_STAR        = 6'd5;
   localparam kind_type K_PERCENT     = 6'd6;
   localparam kind_type K_CARET       = 6'd7;
   localparam kind_type K_COMMA       = 6'd8;
   localparam kind_type K_QUEST       = 6'd9;
   localparam kind_type K_COLON       = 6'd10;
   localparam kind_type K_SEMI        = 6'd11;
   localparam kind_type K_LPAREN      = 6'd12;
   localparam kind_type K_RPAREN      = 6'd13;
   localparam kind_type K_LBRACE      = 6'd14;
   localparam kind_type K_RBRACE      = 6'd15;
   localparam kind_type K_DEC         = 6'd16;
   localparam kind_type K_MINUS       = 6'd17;
   localparam kind_type K_INC         = 6'd18;
   localparam kind_type K_PLUS        = 6'd19;
   localparam kind_type K_NE          = 6'd20;
   localparam kind_type K_NOT         = 6'd21;
   localparam kind_type K_EQ          = 6'd22;
   localparam kind_type K_ASSIGN      = 6'd23;
   localparam kind_type K_LOR         = 6'd24;
   localparam kind_type K_BOR         = 6'd25;
   localparam kind_type K_LAND        = 6'd26;
   localparam kind_type K_BAND        = 6'd27;
   localparam kind_type K_DIV         = 6'd28;
   localparam kind_type K_LE          = 6'd29;
   localparam kind_type K_SHL         = 6'd30;
   localparam kind_type K_LT          = 6'd31;
   localparam kind_type K_GE          = 6'd32;
   localparam kind_type K_SHR         = 6'd33;
   localparam kind_type K_GT          = 6'd34;
   localparam kind_type K_ERR_COMMENT = 6'd35;
   localparam kind_type K_ERR_EXP     = 6'd36;
   localparam kind_type K_ERR_CHAR    = 6'd37;
   localparam kind_type K_NONE        = 6'd0;

   typedef enum logic [3:0] {
      M_IDLE     = 4'd0,
      M_IDENT    = 4'd1,
      M_INT      = 4'd2,
      M_ZERO     = 4'd3,
      M_FRAC     = 4'd4,
      M_EXP_E    = 4'd5,
      M_EXP_BODY = 4'd6,
      M_OP       = 4'd7,
      M_LINE     = 4'd8,
      M_BLOCK    = 4'd9
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic [OFS_W-1:0]   token_start;
      logic [LEN_W-1:0]   pending_length;
      logic [OFS_W-1:0]   byte_offset;
      logic [DEPTH_W-1:0] comment_depth;
      logic               exp_seen;
      logic [7:0]         held_char;
   } scan_state_type;

   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic [OFS_W-1:0] start;
      kind_type         kind;
   } result_type;

   typedef struct packed {
      logic [RES_IDX_W-1:0]         count;
      result_type [RES_PER_ITEM-1:0] res;
   } group_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_head(logic [7:0] c);
      return (c == "_") || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d) ||
             (c == 8'h0b) || (c == 8'h0c);
   endfunction

   function automatic logic [LEN_W-1:0] grow(logic [LEN_W-1:0] x);
      return (x != '1) ? x + 1'b1 : x;
   endfunction

   function automatic kind_type single_kind(logic [7:0] c);
      kind_type k;
      case (c)
         "~":     k = K_TILDE;
         "*":     k = K_STAR;
         "%":     k = K_PERCENT;
         "^":     k = K_CARET;
         ",":     k = K_COMMA;
         "?":     k = K_QUEST;
         ":":     k = K_COLON;
         ";":     k = K_SEMI;
         "(":     k = K_LPAREN;
         ")":     k = K_RPAREN;
         "{":     k = K_LBRACE;
         "}":     k = K_RBRACE;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   // two-character operator completed by c, else K_NONE
   function automatic kind_type pair_kind(logic [7:0] first, logic [7:0] c);
      kind_type k;
      k = K_NONE;
      case (first)
         "-": if (c == "-") k = K_DEC;
         "+": if (c == "+") k = K_INC;
         "!": if (c == "=") k = K_NE;
         "=": if (c == "=") k = K_EQ;
         "|": if (c == "|") k = K_LOR;
         "&": if (c == "&") k = K_LAND;
         "<": begin
            if (c == "=") k = K_LE;
            else if (c == "<") k = K_SHL;
         end
         ">": begin
            if (c == "=") k = K_GE;
            else if (c == ">") k = K_SHR;
         end
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   function automatic kind_type lone_kind(logic [7:0] first);
      kind_type k;
      case (first)
         "-":     k = K_MINUS;
         "+":     k = K_PLUS;
         "!":     k = K_NOT;
         "=":     k = K_ASSIGN;
         "|":     k = K_BOR;
         "&":     k = K_BAND;
         "<":     k = K_LT;
         ">":     k = K_GT;
         default: k = K_DIV;
      endcase
      return k;
   endfunction

   // append one result to a group, dropping anything past the third
   function automatic group_type push_res(group_type g, kind_type kind,
                                          logic [OFS_W-1:0] start,
                                          logic [LEN_W-1:0] length);
      group_type r;
      r = g;
      if (32'(g.count) < RES_PER_ITEM) begin
         r.res[g.count].kind   = kind;
         r.res[g.count].start  = start;
         r.res[g.count].length = length;
         r.count = g.count + 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/c_like_token_scanner.sv =====
// ----------------------------------------------------------------------------
// c_like_token_scanner
// Streaming scanner for C-like source text: one byte in, zero to three
// tokens out (kind, start offset, length), tlast on the byte's final token.
// ----------------------------------------------------------------------------
// Path: byte accepted -> input register -> result queue -> output stage.
// Throughput: one byte per cycle while each byte yields at most one token
//   and rsp is not stalled; a byte with n tokens sends n results, buffered
//   by a four-group result queue behind the input register.
// Reset: synchronous, clears scan state, offset, queue and output stage.
module c_like_token_scanner (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] char_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ctls_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [5:0] token_kind,
                                                          // [21:6] start_offset,
                                                          // [37:22] token_length,
                                                          // [39:38] zero
   output logic                              rsp_tlast    // last_of_run
);
   import ctls_pkg::*;

   logic             in_vld_ff, in_vld_in;
   logic [7:0]       in_char_ff, in_char_in;
   scan_state_type   state_ff, state_in;
   scan_state_type   step_state;
   group_type        step_group;
   logic             step_end;
   logic             q_full;
   logic             step_fire;

   ctls_step u_step (
      .state_cur (state_ff),
      .char_in   (in_char_ff),
      .state_nxt (step_state),
      .group     (step_group),
      .at_end    (step_end)
   );

   ctls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (step_fire && (step_group.count != '0)),
      .group_in   (step_group),
      .full       (q_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always_comb begin
      step_fire  = in_vld_ff && !q_full;
      req_tready = !in_vld_ff || !q_full;
      in_vld_in  = in_vld_ff;
      in_char_in = in_char_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in  = 1'b1;
         in_char_in = req_tdata;
      end else if (step_fire) begin
         in_vld_in  = 1'b0;
      end
      state_in = step_fire ? step_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         state_ff  <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         state_ff  <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
   end

   // a block comment always has at least one open level
   a_block_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == M_BLOCK) |-> (state_ff.comment_depth != '0))
      else $error("block comment with zero depth");

   // any token in progress has a nonzero length
   a_pending_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode != M_IDLE) |-> (state_ff.pending_length != '0))
      else $error("token in progress with zero length");

   // end of text restarts offsets at zero
   a_end_restart: assert property (@(posedge clock) disable iff (reset)
      (step_fire && step_end) |=> (state_ff.byte_offset == '0) &&
                                  (state_ff.mode == M_IDLE))
      else $error("end of text did not restart the scanner");

   // a stalled byte leaves the scan state untouched
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && q_full) |=> $stable(state_ff))
      else $error("scan state moved while stalled");

endmodule

// ===== rtl/core/ctls_step.sv =====
// ----------------------------------------------------------------------------
// ctls_step
// Next-state and result logic for one source byte.
// ----------------------------------------------------------------------------
module ctls_step (
   input  ctls_pkg::scan_state_type state_cur,
   input  logic [7:0]               char_in,
   output ctls_pkg::scan_state_type state_nxt,
   output ctls_pkg::group_type      group,
   output logic                     at_end
);
   import ctls_pkg::*;

   always_comb begin
      scan_state_type s;
      group_type      g;
      logic           idle_path;
      logic           done;
      kind_type       k;

      s         = state_cur;
      g         = '0;
      idle_path = 1'b0;
      done      = 1'b0;
      k         = pair_kind(state_cur.held_char, char_in);

      unique case (state_cur.mode)
         M_IDENT: begin
            if (is_head(char_in) || is_digit(char_in)) begin
               s.pending_length = grow(s.pending_length);
            end else begin
               g = push_res(g, K_IDENT, s.token_start, s.pending_length);
               idle_path = 1'b1;
            end
         end
         M_INT, M_ZERO: begin
            if ((state_cur.mode == M_INT) && is_digit(char_in)) begin
               s.pending_length = grow(s.pending_length);
            end else if (char_in == ".") begin
               s.mode = M_FRAC;
               s.pending_length = grow(s.pending_length);
            end else begin
               g = push_res(g, K_INT, s.token_start, s.pending_length);
               idle_path = 1'b1;
            end
         end
         M_FRAC: begin
            if (is_digit(char_in)) begin
               s.pending_length = grow(s.pending_length);
            end else if ((char_in == "e") || (char_in == "E")) begin
               s.mode = M_EXP_E;
               s.exp_seen = 1'b0;
               s.pending_length = grow(s.pending_length);
            end else begin
               s.exp_seen = 1'b1;
               g = push_res(g, K_FLOAT, s.token_start, s.pending_length);
               idle_path = 1'b1;
            end
         end
         M_EXP_E, M_EXP_BODY: begin
            if (is_digit(char_in)) begin
               s.exp_seen = 1'b1;
               s.mode = M_EXP_BODY;
               s.pending_length = grow(s.pending_length);
            end else if ((state_cur.mode == M_EXP_E) &&
                         ((char_in == "+") || (char_in == "-"))) begin
               s.mode = M_EXP_BODY;
               s.pending_length = grow(s.pending_length);
            end else begin
               // missing exponent digits: error points at this byte
               if (!s.exp_seen) g = push_res(g, K_ERR_EXP, s.byte_offset, '0);
               g = push_res(g, K_FLOAT, s.token_start, s.pending_length);
               idle_path = 1'b1;
            end
         end
         M_OP: begin
            if ((state_cur.held_char == "/") && (char_in == "/")) begin
               s.mode = M_LINE;
               s.held_char = '0;
            end else if ((state_cur.held_char == "/") && (char_in == "*")) begin
               s.mode = M_BLOCK;
               s.comment_depth = DEPTH_W'(1);
               s.held_char = '0;
               s.pending_length = grow(s.pending_length);
            end else if (k != K_NONE) begin
               g = push_res(g, k, s.token_start, LEN_W'(2));
               s.mode = M_IDLE;
               s.held_char = '0;
            end else begin
               g = push_res(g, lone_kind(state_cur.held_char), s.token_start, LEN_W'(1));
               s.held_char = '0;
               idle_path = 1'b1;
            end
         end
         M_LINE: begin
            if ((char_in == 8'h0a) || (char_in == 8'h0d)) s.mode = M_IDLE;
            else if (char_in == 8'h00) idle_path = 1'b1;
         end
         M_BLOCK: begin
            if (char_in == 8'h00) begin
               g = push_res(g, K_ERR_COMMENT, s.token_start, s.pending_length);
               idle_path = 1'b1;
            end else begin
               s.pending_length = grow(s.pending_length);
               if ((state_cur.held_char == "/") && (char_in == "*")) begin
                  if (32'(s.comment_depth) < MAX_COMMENT_DEPTH) begin
                     s.comment_depth = s.comment_depth + 1'b1;
                  end
                  s.held_char = '0;
               end else if ((state_cur.held_char == "*") && (char_in == "/")) begin
                  s.held_char = '0;
                  if (s.comment_depth != '0) s.comment_depth = s.comment_depth - 1'b1;
                  if (s.comment_depth == '0) s.mode = M_IDLE;
               end else begin
                  s.held_char = ((char_in == "/") || (char_in == "*")) ? char_in : 8'h00;
               end
            end
         end
         default: idle_path = 1'b1;
      endcase

      // byte taken as if between tokens
      if (idle_path) begin
         s.mode = M_IDLE;
         if (char_in == 8'h00) begin
            g = push_res(g, K_EOF, s.byte_offset, '0);
            done = 1'b1;
         end else if (is_space(char_in)) begin
            s.mode = M_IDLE;
         end else if (single_kind(char_in) != K_NONE) begin
            g = push_res(g, single_kind(char_in), s.byte_offset, LEN_W'(1));
         end else if ((char_in == "/") || (lone_kind(char_in) != K_DIV)) begin
            s.mode = M_OP;
            s.token_start = s.byte_offset;
            s.pending_length = LEN_W'(1);
            s.held_char = char_in;
         end else if (char_in == "0") begin
            s.mode = M_ZERO;
            s.token_start = s.byte_offset;
            s.pending_length = LEN_W'(1);
         end else if (is_digit(char_in)) begin
            s.mode = M_INT;
            s.token_start = s.byte_offset;
            s.pending_length = LEN_W'(1);
         end else if (is_head(char_in)) begin
            s.mode = M_IDENT;
            s.token_start = s.byte_offset;
            s.pending_length = LEN_W'(1);
         end else begin
            g = push_res(g, K_ERR_CHAR, s.byte_offset, LEN_W'(1));
         end
      end

      if (done) begin
         s = '0;
         s.mode = M_IDLE;
      end else begin
         s.byte_offset = s.byte_offset + 1'b1;
      end

      state_nxt = s;
      group     = g;
      at_end    = done;
   end

endmodule

// ===== rtl/core/ctls_queue.sv =====
// ----------------------------------------------------------------------------
// ctls_queue
// Queue of per-byte result groups, drained one result per cycle into a
// registered output stage while that stage is not stalled by rsp_tready.
// ----------------------------------------------------------------------------
module ctls_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  ctls_pkg::group_type                 group_in,
   output logic                                full,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ctls_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);
   import ctls_pkg::*;

   group_type              mem_ff [QDEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]      cnt_ff, cnt_in;
   logic [RES_IDX_W-1:0]   sub_ff, sub_in;
   logic                   out_vld_ff, out_vld_in;
   result_type             out_res_ff, out_res_in;
   logic                   out_last_ff, out_last_in;

   group_type              head;
   result_type             sel;
   logic                   load;
   logic                   head_last;
   logic                   pop;

   always_comb begin
      head      = mem_ff[rd_ptr_ff];
      sel       = head.res[sub_ff];
      head_last = (sub_ff == (head.count - 1'b1));
      load      = (cnt_ff != '0) && (!out_vld_ff || rsp_tready);
      pop       = load && head_last;
      full      = (cnt_ff == QCNT_W'(QDEPTH));

      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
      sub_in    = sub_ff;
      if (load) sub_in = head_last ? '0 : sub_ff + 1'b1;

      out_vld_in  = out_vld_ff;
      out_res_in  = out_res_ff;
      out_last_in = out_last_ff;
      if (load) begin
         out_vld_in  = 1'b1;
         out_res_in  = sel;
         out_last_in = head_last;
      end else if (rsp_tready) begin
         out_vld_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         cnt_ff     <= '0;
         sub_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         cnt_ff     <= cnt_in;
         sub_ff     <= sub_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= group_in;
      out_res_ff  <= out_res_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - LEN_W - OFS_W - KIND_W){1'b0}},
                        out_res_ff.length, out_res_ff.start, out_res_ff.kind};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== test/tb_c_like_token_scanner.sv =====
// ----------------------------------------------------------------------------
// tb_c_like_token_scanner
// Feeds source text byte by byte into the token scanner. A short directed
// table comes first, then random text: mostly well-formed tokens and comments
// mixed with stray bytes. The bench also feeds one nested block comment.
// Every token that comes out is checked against the directed table or a scanner
// model kept in the bench, while both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_c_like_token_scanner;
   timeunit 1ns;
   timeprecision 1ps;
   import ctls_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 64;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 10;
   localparam int NEST_OPEN    = 3;

   typedef struct {
      kind_type         kind;
      logic [OFS_W-1:0] start;
      logic [LEN_W-1:0] length;
      logic             last;
   } token_rec;

   typedef struct {
      logic [7:0]       c;
      bit               typed;
      kind_type         kind;
      logic [OFS_W-1:0] start;
      logic [LEN_W-1:0] length;
   } stim_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'h00;   // [7:0] char_in
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;           // [5:0] kind, [21:6] start, [37:22] length
   logic                  rsp_tlast;

   c_like_token_scanner u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // directed table; typed rows carry their single token, others use the model
   stim_row dir_rows [26] = '{
      '{8'h00, 1'b1, K_EOF,      16'd0, 16'd0},   // end token straight after reset
      '{"~",   1'b1, K_TILDE,    16'd0, 16'd1},
      '{8'hff, 1'b1, K_ERR_CHAR, 16'd1, 16'd1},
      '{8'h80, 1'b1, K_ERR_CHAR, 16'd2, 16'd1},
      '{"0",   1'b0, K_NONE,     16'd0, 16'd0},   // leading zero splits "01"
      '{"1",   1'b0, K_NONE,     16'd0, 16'd0},
      '{".",   1'b0, K_NONE,     16'd0, 16'd0},
      '{"e",   1'b0, K_NONE,     16'd0, 16'd0},
      '{";",   1'b0, K_NONE,     16'd0, 16'd0},   // exponent with no digits: three tokens
      '{"<",   1'b0, K_NONE,     16'd0, 16'd0},
      '{"<",   1'b0, K_NONE,     16'd0, 16'd0},
      '{"/",   1'b0, K_NONE,     16'd0, 16'd0},
      '{"*",   1'b0, K_NONE,     16'd0, 16'd0},
      '{"/",   1'b0, K_NONE,     16'd0, 16'd0},
      '{"*",   1'b0, K_NONE,     16'd0, 16'd0},
      '{"*",   1'b0, K_NONE,     16'd0, 16'd0},
      '{"/",   1'b0, K_NONE,     16'd0, 16'd0},
      '{8'h00, 1'b0, K_NONE,     16'd0, 16'd0},   // text ends inside a block comment
      '{"/",   1'b0, K_NONE,     16'd0, 16'd0},
      '{"/",   1'b0, K_NONE,     16'd0, 16'd0},
      '{"Q",   1'b0, K_NONE,     16'd0, 16'd0},
      '{8'h00, 1'b1, K_EOF,      16'd3, 16'd0},   // text ends inside a line comment
      '{"_",   1'b0, K_NONE,     16'd0, 16'd0},
      '{"z",   1'b0, K_NONE,     16'd0, 16'd0},
      '{8'h7f, 1'b0, K_NONE,     16'd0, 16'd0},
      '{8'h00, 1'b1, K_EOF,      16'd3, 16'd0}
   };

   logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0a, 8'h0d, 8'h0b, 8'h0c};

   // scanner model state
   mode_type         scan_mode_q;
   logic [OFS_W-1:0] tok_start;
   logic [LEN_W-1:0] tok_len;
   logic [OFS_W-1:0] byte_ofs;
   int               nest;
   bit               exp_digit;
   logic [7:0]       held;

   token_rec   byte_tokens[$];
   token_rec   tokens_due[$];
   logic [7:0] src_text[$];

   int bytes_sent;
   int tokens_checked;
   int mismatches;
   int idle_cycles;
   bit sender_calm;
   bit receiver_calm;
   bit long_hold_done;
   bit kind_seen [64];

   function automatic void clear_scan();
      scan_mode_q = M_IDLE;
      tok_start   = '0;
      tok_len     = '0;
      byte_ofs    = '0;
      nest        = 0;
      exp_digit   = 1'b0;
      held        = 8'h00;
   endfunction

   function automatic bit is_dec(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic bit is_word(logic [7:0] c);
      return (c == "_") || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
   endfunction

   function automatic logic [LEN_W-1:0] sat_inc(logic [LEN_W-1:0] x);
      return (x == 16'hffff) ? x : x + 16'd1;
   endfunction

   function automatic void add_token(kind_type k, logic [OFS_W-1:0] s, logic [LEN_W-1:0] n);
      token_rec t;
      t = '{k, s, n, 1'b0};
      if (byte_tokens.size() < RES_PER_ITEM) byte_tokens.push_back(t);
   endfunction

   function automatic void open_token(mode_type m);
      scan_mode_q = m;
      tok_start   = byte_ofs;
      tok_len     = 16'd1;
   endfunction

   function automatic void close_float();
      if (!exp_digit) add_token(K_ERR_EXP, byte_ofs, 16'd0);
      add_token(K_FLOAT, tok_start, tok_len);
   endfunction

   // byte seen between tokens; returns 1 at end of text
   function automatic bit idle_byte(logic [7:0] c);
      kind_type k;
      scan_mode_q = M_IDLE;
      k = K_NONE;
      if (c == 8'h00) begin
         add_token(K_EOF, byte_ofs, 16'd0);
         return 1'b1;
      end
      case (c)
         8'h20, 8'h09, 8'h0a, 8'h0d, 8'h0b, 8'h0c: ;
         "~": k = K_TILDE;
         "*": k = K_STAR;
         "%": k = K_PERCENT;
         "^": k = K_CARET;
         ",": k = K_COMMA;
         "?": k = K_QUEST;
         ":": k = K_COLON;
         ";": k = K_SEMI;
         "(": k = K_LPAREN;
         ")": k = K_RPAREN;
         "{": k = K_LBRACE;
         "}": k = K_RBRACE;
         "-", "+", "!", "=", "|", "&", "<", ">", "/": begin
            open_token(M_OP);
            held = c;
         end
         "0": open_token(M_ZERO);
         default: begin
            if (is_dec(c)) open_token(M_INT);
            else if (is_word(c)) open_token(M_IDENT);
            else add_token(K_ERR_CHAR, byte_ofs, 16'd1);
         end
      endcase
      if (k != K_NONE) add_token(k, byte_ofs, 16'd1);
      return 1'b0;
   endfunction

   // advance the model by one byte, leaving its tokens in byte_tokens
   function automatic void scan_byte(logic [7:0] c);
      bit       at_end;
      bit       two;
      kind_type k;
      token_rec t;
      at_end = 1'b0;
      byte_tokens.delete();
      case (scan_mode_q)
         M_IDENT: begin
            if (is_word(c) || is_dec(c)) tok_len = sat_inc(tok_len);
            else begin
               add_token(K_IDENT, tok_start, tok_len);
               at_end = idle_byte(c);
            end
         end
         M_INT, M_ZERO: begin
            if (scan_mode_q == M_INT && is_dec(c)) tok_len = sat_inc(tok_len);
            else if (c == ".") begin
               scan_mode_q = M_FRAC;
               tok_len = sat_inc(tok_len);
            end else begin
               add_token(K_INT, tok_start, tok_len);
               at_end = idle_byte(c);
            end
         end
         M_FRAC: begin
            if (is_dec(c)) tok_len = sat_inc(tok_len);
            else if (c == "e" || c == "E") begin
               scan_mode_q = M_EXP_E;
               exp_digit = 1'b0;
               tok_len = sat_inc(tok_len);
            end else begin
               exp_digit = 1'b1;
               close_float();
               at_end = idle_byte(c);
            end
         end
         M_EXP_E, M_EXP_BODY: begin
            if (is_dec(c)) begin
               exp_digit = 1'b1;
               scan_mode_q = M_EXP_BODY;
               tok_len = sat_inc(tok_len);
            end else if (scan_mode_q == M_EXP_E && (c == "+" || c == "-")) begin
               scan_mode_q = M_EXP_BODY;
               tok_len = sat_inc(tok_len);
            end else begin
               close_float();
               at_end = idle_byte(c);
            end
         end
         M_OP: begin
            if (held == "/" && c == "/") begin
               scan_mode_q = M_LINE;
               held = 8'h00;
            end else if (held == "/" && c == "*") begin
               scan_mode_q = M_BLOCK;
               nest = 1;
               held = 8'h00;
               tok_len = sat_inc(tok_len);
            end else begin
               case (held)
                  "-": begin two = (c == "-"); k = two ? K_DEC : K_MINUS; end
                  "+": begin two = (c == "+"); k = two ? K_INC : K_PLUS; end
                  "!": begin two = (c == "="); k = two ? K_NE : K_NOT; end
                  "=": begin two = (c == "="); k = two ? K_EQ : K_ASSIGN; end
                  "|": begin two = (c == "|"); k = two ? K_LOR : K_BOR; end
                  "&": begin two = (c == "&"); k = two ? K_LAND : K_BAND; end
                  "<": begin
                     two = (c == "=") || (c == "<");
                     k = (c == "=") ? K_LE : ((c == "<") ? K_SHL : K_LT);
                  end
                  ">": begin
                     two = (c == "=") || (c == ">");
                     k = (c == "=") ? K_GE : ((c == ">") ? K_SHR : K_GT);
                  end
                  default: begin two = 1'b0; k = K_DIV; end
               endcase
               held = 8'h00;
               if (two) begin
                  add_token(k, tok_start, 16'd2);
                  scan_mode_q = M_IDLE;
               end else begin
                  add_token(k, tok_start, 16'd1);
                  at_end = idle_byte(c);
               end
            end
         end
         M_LINE: begin
            if (c == 8'h0a || c == 8'h0d) scan_mode_q = M_IDLE;
            else if (c == 8'h00) at_end = idle_byte(c);
         end
         M_BLOCK: begin
            if (c == 8'h00) begin
               add_token(K_ERR_COMMENT, tok_start, tok_len);
               at_end = idle_byte(c);
            end else begin
               tok_len = sat_inc(tok_len);
               if (held == "/" && c == "*") begin
                  if (nest < MAX_COMMENT_DEPTH) nest++;
                  held = 8'h00;
               end else if (held == "*" && c == "/") begin
                  held = 8'h00;
                  if (nest > 0) nest--;
                  if (nest == 0) scan_mode_q = M_IDLE;
               end else begin
                  held = (c == "/" || c == "*") ? c : 8'h00;
               end
            end
         end
         default: at_end = idle_byte(c);
      endcase
      if (at_end) clear_scan();
      else byte_ofs = byte_ofs + 16'd1;
      if (byte_tokens.size() > 0) begin
         t = byte_tokens.pop_back();
         t.last = 1'b1;
         byte_tokens.push_back(t);
      end
   endfunction

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic void put(string s);
      foreach (s[i]) src_text.push_back(s[i]);
   endfunction

   // append one random piece of source text
   function automatic void add_fragment();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
         src_text.push_back(pick("_abcxyzABQZ"));
         repeat ($urandom_range(0, 6)) src_text.push_back(pick("_azAZ09m5"));
      end else if (sel < 34) begin
         src_text.push_back(($urandom_range(0, 3) == 0) ? "0" : pick("123456789"));
         repeat ($urandom_range(0, 4)) src_text.push_back(pick("0123456789"));
      end else if (sel < 44) begin
         repeat ($urandom_range(1, 3)) src_text.push_back(pick("0123456789"));
         src_text.push_back(".");
         repeat ($urandom_range(0, 3)) src_text.push_back(pick("0123456789"));
         if ($urandom_range(0, 2) != 0) begin
            src_text.push_back(pick("eE"));
            if ($urandom_range(0, 1)) src_text.push_back(pick("+-"));
            repeat ($urandom_range(0, 2)) src_text.push_back(pick("0123456789"));
         end
      end else if (sel < 64) begin
         src_text.push_back(pick("~*%^,?:;(){}-+!=|&<>/"));
         if ($urandom_range(0, 1)) src_text.push_back(pick("-+=|&<>"));
      end else if (sel < 74) begin
         repeat ($urandom_range(1, 3)) src_text.push_back(blanks[$urandom_range(0, 5)]);
      end else if (sel < 79) begin
         put("//");
         repeat ($urandom_range(0, 8)) src_text.push_back(8'($urandom_range(32, 126)));
         src_text.push_back($urandom_range(0, 1) ? 8'h0a : 8'h0d);
      end else if (sel < 85) begin
         put("/*");
         repeat ($urandom_range(0, 10)) src_text.push_back(pick("ab */\n"));
         put("*/");
      end else if (sel < 90) begin
         src_text.push_back(8'h00);
      end else begin
         src_text.push_back(8'($urandom_range(0, 255)));   // stray byte
      end
      if ($urandom_range(0, 2) == 0) src_text.push_back(8'h20);
   endfunction

   task automatic feed_byte(input logic [7:0] c);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_char(input stim_row r);
      feed_byte(r.c);
      scan_byte(r.c);
      if (r.typed) tokens_due.push_back('{r.kind, r.start, r.length, 1'b1});
      else foreach (byte_tokens[i]) tokens_due.push_back(byte_tokens[i]);
   endtask

   task automatic send_text(input bit steady);
      stim_row r;
      sender_calm = steady;
      while (src_text.size() > 0) begin
         r = '{src_text.pop_front(), 1'b0, K_NONE, 16'd0, 16'd0};
         send_char(r);
         if (!steady && $urandom_range(0, 29) == 0) sender_calm = !sender_calm;
      end
      sender_calm = 1'b0;
   endtask

   // sender stays quiet until every token due has come back
   task automatic await_tokens();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tokens_due.size() != 0);
   endtask

   // result side: random stalls, one long hold-off, compare against the tokens due
   initial begin : drain_tokens
      int         stall;
      result_type word;
      token_rec   want;
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && tokens_checked >= 60) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end
         stall = receiver_calm ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         word = rsp_tdata[37:0];
         kind_seen[word.kind] = 1'b1;
         if (tokens_due.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("token %0d: none due, got kind %0d start %0d len %0d last %0b",
                        tokens_checked, word.kind, word.start, word.length, rsp_tlast);
            mismatches++;
         end else begin
            want = tokens_due.pop_front();
            if (word.kind !== want.kind || word.start !== want.start ||
                word.length !== want.length || rsp_tlast !== want.last) begin
               if (mismatches < MAX_REPORTS)
                  $display({"token %0d: expected kind %0d start %0d len %0d last %0b,",
                            " got kind %0d start %0d len %0d last %0b"},
                           tokens_checked, want.kind, want.start, want.length, want.last,
                           word.kind, word.start, word.length, rsp_tlast);
               mismatches++;
            end
         end
         tokens_checked++;
         if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("tb_c_like_token_scanner NOT OK");
            $finish;
         end
      end
   end

   initial begin : run_text
      int kinds;
      clear_scan();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_char(dir_rows[i]);
      await_tokens();

      while (src_text.size() < 185) add_fragment();
      send_text(1'b0);
      await_tokens();

      // nested block comment sent back to back, closed level by level
      repeat (NEST_OPEN) put("/*");
      repeat (NEST_OPEN) put("*/");
      put("k");
      src_text.push_back(8'h00);
      send_text(1'b1);

      while (src_text.size() < 185) add_fragment();
      send_text(1'b0);
      await_tokens();
      repeat (DRAIN_CYCLES) @(posedge clock);

      kinds = 0;
      foreach (kind_seen[i]) if (kind_seen[i]) kinds++;
      $display("fed %0d bytes, checked %0d tokens covering %0d of 38 token kinds",
               bytes_sent, tokens_checked, kinds);
      $display("included a comment nested %0d deep, %0d mismatches",
               NEST_OPEN, mismatches);
      if (mismatches == 0) begin
         $display("tb_c_like_token_scanner OK");
      end else begin
         $display("tb_c_like_token_scanner NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/ctls_pkg.sv
rtl/core/ctls_step.sv
rtl/core/ctls_queue.sv
rtl/core/c_like_token_scanner.sv
test/tb_c_like_token_scanner.sv
